>>> rtl/prqs_pkg.sv
// ----------------------------------------------------------------------------
// prqs_pkg
// shared types, sizes and helpers of the priority ready queue scheduler
// ----------------------------------------------------------------------------
package prqs_pkg;

    localparam int MAX_THREADS = 32;
    localparam int PRIO_LEVELS = 64;

    localparam int MODE_W = 2;
    localparam int ID_W   = 5;
    localparam int PRIO_W = 6;
    localparam int IDX_W  = $clog2(MAX_THREADS);
    localparam int CNT_W  = $clog2(MAX_THREADS + 1);

    localparam int S_TDATA_W = ((MODE_W + ID_W + PRIO_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ID_W + 4 + CNT_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_READY   = 2'd0,
        MODE_RESCHED = 2'd1,
        MODE_KILL    = 2'd2,
        MODE_SUSPEND = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESCHED,
        S_INS_START,
        S_INS_CMP,
        S_INS_DONE,
        S_POP,
        S_POP_WAIT,
        S_KILL,
        S_KILL_DONE,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
    } t_mem_req;

    typedef struct packed {
        t_mode             mode;
        logic [ID_W-1:0]   thread_id;
        logic [PRIO_W-1:0] priority_req;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] ready_count;
        logic             queue_full;
        logic             switched;
        logic             idle;
        logic             running_valid;
        logic [ID_W-1:0]  running_id;
    } t_result;

    // queue position relative to the head, mapped onto the circular memory
    function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                   input logic [CNT_W-1:0] lidx);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(lidx);
        if (sum >= (CNT_W+1)'(MAX_THREADS)) begin
            sum = sum - (CNT_W+1)'(MAX_THREADS);
        end
        return sum[IDX_W-1:0];
    endfunction

    // out-of-range priorities clamp to the least urgent level
    function automatic logic [PRIO_W-1:0] sat_prio(input logic [PRIO_W-1:0] p);
        logic [PRIO_W-1:0] r;
        r = p;
        if (int'(p) >= PRIO_LEVELS) begin
            r = PRIO_W'(PRIO_LEVELS - 1);
        end
        return r;
    endfunction

endpackage

>>> rtl/prqs_qmem.sv
// ----------------------------------------------------------------------------
// prqs_qmem
// queue entry store: one write and one registered read port
// ----------------------------------------------------------------------------
module prqs_qmem (
    input  logic               i_clk,
    input  prqs_pkg::t_mem_req i_req,
    output prqs_pkg::t_entry   o_rdata
);

    prqs_pkg::t_entry mem [prqs_pkg::MAX_THREADS];
    prqs_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/prqs_ctrl.sv
// ----------------------------------------------------------------------------
// prqs_ctrl
// sequencer for insert, kill, re-queue and pop over the entry memory
// ----------------------------------------------------------------------------
module prqs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  prqs_pkg::t_cmd     i_cmd,
    output logic               o_ready,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output prqs_pkg::t_result  o_res,
    output prqs_pkg::t_mem_req o_mem_req,
    input  prqs_pkg::t_entry   i_mem_rdata
);

    localparam int IDX_W = prqs_pkg::IDX_W;
    localparam int CNT_W = prqs_pkg::CNT_W;
    localparam int ID_W  = prqs_pkg::ID_W;
    localparam int PRIO_W = prqs_pkg::PRIO_W;

    prqs_pkg::t_state r_state, n_state;

    logic [IDX_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_len, n_len;
    logic [ID_W-1:0]   r_cur_slot, n_cur_slot;
    logic [PRIO_W-1:0] r_cur_prio, n_cur_prio;
    logic              r_running, n_running;
    logic              r_known, n_known;
    logic              r_idle, n_idle;
    logic              r_switched, n_switched;
    logic              r_full, n_full;
    logic              r_pend, n_pend;
    logic              r_found, n_found;
    logic              r_requeue, n_requeue;
    logic [ID_W-1:0]   r_id, n_id;
    logic [ID_W-1:0]   r_tid, n_tid;
    logic [PRIO_W-1:0] r_tprio, n_tprio;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_didx, n_didx;

    logic              full_now;
    logic [CNT_W-1:0]  idx_m1;
    logic [CNT_W-1:0]  idx_m2;
    prqs_pkg::t_entry  new_entry;

    assign full_now  = (r_len >= CNT_W'(prqs_pkg::MAX_THREADS));
    assign idx_m1    = r_idx - CNT_W'(1);
    assign idx_m2    = r_idx - CNT_W'(2);
    assign new_entry = '{id: r_tid, prio: r_tprio};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prqs_pkg::S_IDLE: begin
                if (i_start) begin
                    unique case (i_cmd.mode)
                        prqs_pkg::MODE_READY: begin
                            n_state = full_now ? prqs_pkg::S_FIN : prqs_pkg::S_INS_START;
                        end
                        prqs_pkg::MODE_KILL: n_state = prqs_pkg::S_KILL;
                        prqs_pkg::MODE_RESCHED,
                        prqs_pkg::MODE_SUSPEND: n_state = prqs_pkg::S_RESCHED;
                        default: n_state = prqs_pkg::S_IDLE;
                    endcase
                end
            end
            prqs_pkg::S_RESCHED: begin
                if (r_known && r_running) begin
                    n_state = full_now ? prqs_pkg::S_FIN : prqs_pkg::S_INS_START;
                end else begin
                    n_state = prqs_pkg::S_POP;
                end
            end
            prqs_pkg::S_INS_START: begin
                n_state = (r_idx == '0) ? prqs_pkg::S_INS_DONE : prqs_pkg::S_INS_CMP;
            end
            prqs_pkg::S_INS_CMP: begin
                // an entry that moves up on the last position leaves the head slot open
                if (i_mem_rdata.prio > r_tprio) begin
                    if (idx_m1 == '0) begin
                        n_state = prqs_pkg::S_INS_START;
                    end
                end else begin
                    n_state = prqs_pkg::S_INS_DONE;
                end
            end
            prqs_pkg::S_INS_DONE: begin
                n_state = r_requeue ? prqs_pkg::S_POP : prqs_pkg::S_FIN;
            end
            prqs_pkg::S_POP: begin
                n_state = (r_len == '0) ? prqs_pkg::S_FIN : prqs_pkg::S_POP_WAIT;
            end
            prqs_pkg::S_POP_WAIT: n_state = prqs_pkg::S_FIN;
            prqs_pkg::S_KILL: begin
                if (!r_pend && (r_k >= r_len)) begin
                    n_state = prqs_pkg::S_KILL_DONE;
                end
            end
            prqs_pkg::S_KILL_DONE: n_state = prqs_pkg::S_RESCHED;
            prqs_pkg::S_FIN: begin
                if (i_res_ready) begin
                    n_state = prqs_pkg::S_IDLE;
                end
            end
            default: n_state = prqs_pkg::S_IDLE;
        endcase
    end

    // datapath and memory accesses
    always_comb begin
        n_head     = r_head;
        n_len      = r_len;
        n_cur_slot = r_cur_slot;
        n_cur_prio = r_cur_prio;
        n_running  = r_running;
        n_known    = r_known;
        n_idle     = r_idle;
        n_switched = r_switched;
        n_full     = r_full;
        n_pend     = r_pend;
        n_found    = r_found;
        n_requeue  = r_requeue;
        n_id       = r_id;
        n_tid      = r_tid;
        n_tprio    = r_tprio;
        n_idx      = r_idx;
        n_k        = r_k;
        n_didx     = r_didx;
        o_mem_req  = '0;

        unique case (r_state)
            prqs_pkg::S_IDLE: begin
                if (i_start) begin
                    n_id       = i_cmd.thread_id;
                    n_idle     = 1'b0;
                    n_switched = 1'b0;
                    n_full     = 1'b0;
                    n_requeue  = 1'b0;
                    unique case (i_cmd.mode)
                        prqs_pkg::MODE_READY: begin
                            n_tid   = i_cmd.thread_id;
                            n_tprio = prqs_pkg::sat_prio(i_cmd.priority_req);
                            n_idx   = r_len;
                            n_full  = full_now;
                        end
                        prqs_pkg::MODE_KILL: begin
                            n_k     = '0;
                            n_pend  = 1'b0;
                            n_found = 1'b0;
                        end
                        prqs_pkg::MODE_SUSPEND: n_running = 1'b0;
                        prqs_pkg::MODE_RESCHED: ;
                        default: ;
                    endcase
                end
            end
            prqs_pkg::S_RESCHED: begin
                if (r_known && r_running) begin
                    if (full_now) begin
                        n_full = 1'b1;
                    end else begin
                        n_tid     = r_cur_slot;
                        n_tprio   = r_cur_prio;
                        n_requeue = 1'b1;
                        n_idx     = r_len;
                    end
                end
            end
            prqs_pkg::S_INS_START: begin
                if (r_idx == '0) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = prqs_pkg::phys_addr(r_head, r_idx);
                    o_mem_req.wdata = new_entry;
                end else begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = prqs_pkg::phys_addr(r_head, idx_m1);
                end
            end
            prqs_pkg::S_INS_CMP: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = prqs_pkg::phys_addr(r_head, r_idx);
                if (i_mem_rdata.prio > r_tprio) begin
                    // shift the less urgent entry one place toward the tail
                    o_mem_req.wdata = i_mem_rdata;
                    n_idx           = idx_m1;
                    if (idx_m1 != '0) begin
                        o_mem_req.re    = 1'b1;
                        o_mem_req.raddr = prqs_pkg::phys_addr(r_head, idx_m2);
                    end
                end else begin
                    o_mem_req.wdata = new_entry;
                end
            end
            prqs_pkg::S_INS_DONE: begin
                n_len = r_len + CNT_W'(1);
                if (r_requeue) begin
                    n_running = 1'b0;
                end else if (r_known && (r_cur_slot == r_tid)) begin
                    n_running = 1'b0;
                end
            end
            prqs_pkg::S_POP: begin
                if (r_len == '0) begin
                    n_idle = 1'b1;
                end else begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = r_head;
                end
            end
            prqs_pkg::S_POP_WAIT: begin
                n_switched = !r_known || (i_mem_rdata.id != r_cur_slot);
                n_cur_slot = i_mem_rdata.id;
                n_cur_prio = i_mem_rdata.prio;
                n_running  = 1'b1;
                n_known    = 1'b1;
                n_head     = (r_head == IDX_W'(prqs_pkg::MAX_THREADS - 1)) ? '0
                                                                          : r_head + IDX_W'(1);
                n_len      = r_len - CNT_W'(1);
            end
            prqs_pkg::S_KILL: begin
                // compare the entry read last cycle, close the gap behind a match
                if (r_pend) begin
                    if (!r_found) begin
                        if (i_mem_rdata.id == r_id) begin
                            n_found = 1'b1;
                        end
                    end else begin
                        o_mem_req.we    = 1'b1;
                        o_mem_req.waddr = prqs_pkg::phys_addr(r_head, r_didx - CNT_W'(1));
                        o_mem_req.wdata = i_mem_rdata;
                    end
                end
                if (r_k < r_len) begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = prqs_pkg::phys_addr(r_head, r_k);
                    n_didx          = r_k;
                    n_pend          = 1'b1;
                    n_k             = r_k + CNT_W'(1);
                end else begin
                    n_pend = 1'b0;
                end
            end
            prqs_pkg::S_KILL_DONE: begin
                if (r_found) begin
                    n_len = r_len - CNT_W'(1);
                end
                if (r_known && (r_cur_slot == r_id)) begin
                    n_running = 1'b0;
                end
            end
            prqs_pkg::S_FIN: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= prqs_pkg::S_IDLE;
            r_head     <= '0;
            r_len      <= '0;
            r_cur_slot <= '0;
            r_cur_prio <= '0;
            r_running  <= 1'b0;
            r_known    <= 1'b0;
            r_idle     <= 1'b0;
            r_switched <= 1'b0;
            r_full     <= 1'b0;
            r_pend     <= 1'b0;
            r_found    <= 1'b0;
            r_requeue  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_len      <= n_len;
            r_cur_slot <= n_cur_slot;
            r_cur_prio <= n_cur_prio;
            r_running  <= n_running;
            r_known    <= n_known;
            r_idle     <= n_idle;
            r_switched <= n_switched;
            r_full     <= n_full;
            r_pend     <= n_pend;
            r_found    <= n_found;
            r_requeue  <= n_requeue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_tid   <= n_tid;
        r_tprio <= n_tprio;
        r_idx   <= n_idx;
        r_k     <= n_k;
        r_didx  <= n_didx;
    end

    assign o_ready     = (r_state == prqs_pkg::S_IDLE);
    assign o_res_valid = (r_state == prqs_pkg::S_FIN);

    always_comb begin
        o_res.running_id    = r_cur_slot;
        o_res.running_valid = r_running;
        o_res.idle          = r_idle;
        o_res.switched      = r_switched;
        o_res.queue_full    = r_full;
        o_res.ready_count   = r_len;
    end

endmodule

>>> rtl/priority_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// priority ordered ready queue with current thread tracking
// ----------------------------------------------------------------------------
//
// channel   dir   fields in tdata (lsb first)
// s_axis    in    mode[1:0] thread_id[6:2] priority_req[12:7] zero[15:13]
// m_axis    out   running_id[4:0] running_valid[5] idle[6] switched[7]
//                 queue_full[8] ready_count[14:9] zero[15]
//
// one command at a time; the queue lives in a circular entry memory with a
// registered read. a command walks the entry memory as far as it needs and
// then loads its result into the output register. reset is synchronous,
// active low; the memory needs no clearing pass since only entries below
// the fill count are read.
// a waiting result does not block the next command: the output register
// holds it while the sequencer takes new work.
//
module priority_ready_queue_scheduler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // mode, thread_id, priority_req
    input  logic [prqs_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // running_id, running_valid, idle, switched, queue_full, ready_count
    output logic [prqs_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready
);

    localparam int MODE_W = prqs_pkg::MODE_W;
    localparam int ID_W   = prqs_pkg::ID_W;
    localparam int PRIO_W = prqs_pkg::PRIO_W;
    localparam int M_W    = prqs_pkg::M_TDATA_W;

    logic                       ctrl_ready;
    logic                       in_xfer;
    prqs_pkg::t_cmd             cmd;
    logic                       res_valid;
    logic                       res_ready;
    prqs_pkg::t_result          res;
    prqs_pkg::t_mem_req         mem_req;
    prqs_pkg::t_entry           mem_rdata;

    logic                       r_m_valid;
    logic [M_W-1:0]             r_m_data;

    // command fields from the input transfer
    assign in_xfer          = i_s_axis_tvalid && ctrl_ready;
    assign cmd.mode         = prqs_pkg::t_mode'(i_s_axis_tdata[MODE_W-1:0]);
    assign cmd.thread_id    = i_s_axis_tdata[MODE_W +: ID_W];
    assign cmd.priority_req = i_s_axis_tdata[MODE_W + ID_W +: PRIO_W];
    assign o_s_axis_tready  = ctrl_ready;

    prqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_xfer),
        .i_cmd       (cmd),
        .o_ready     (ctrl_ready),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    prqs_qmem u_qmem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // output register, refilled as the old result leaves
    assign res_ready = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_m_data <= M_W'({res.ready_count, res.queue_full, res.switched,
                              res.idle, res.running_valid, res.running_id});
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

>>> rtl/prqs_chk.sv
// ----------------------------------------------------------------------------
// prqs_chk
// port level checks of the priority ready queue scheduler
// ----------------------------------------------------------------------------
module prqs_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [prqs_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                           i_s_axis_tvalid,
    input  logic                           o_s_axis_tready,
    input  logic [prqs_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready
);

    logic [prqs_pkg::CNT_W-1:0] cnt;
    logic                       run_v;
    logic                       idle_f;
    logic                       sw_f;

    assign cnt    = o_m_axis_tdata[prqs_pkg::ID_W + 4 +: prqs_pkg::CNT_W];
    assign run_v  = o_m_axis_tdata[prqs_pkg::ID_W];
    assign idle_f = o_m_axis_tdata[prqs_pkg::ID_W + 1];
    assign sw_f   = o_m_axis_tdata[prqs_pkg::ID_W + 2];

    // nothing leaves right after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> cnt <= prqs_pkg::CNT_W'(prqs_pkg::MAX_THREADS))
        else $error("ready count beyond queue depth");

    // an empty-queue reschedule neither switches nor leaves a thread running
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && idle_f |-> !sw_f && !run_v && cnt == '0)
        else $error("idle result inconsistent");

endmodule

bind priority_ready_queue_scheduler prqs_chk u_prqs_chk (.*);

>>> bench/priority_ready_queue_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_tb
// self-checking bench: make-ready, reschedule, kill and suspend commands are
// streamed in with random gaps and back pressure, every result transfer is
// checked field by field against a scheduler predictor kept in a small class
// ----------------------------------------------------------------------------

import prqs_pkg::*;

// predictor of the scheduler plus the store of results still to arrive
class sched_checker;
    t_entry            ready_q[$];
    logic [ID_W-1:0]   cur_id;
    logic [PRIO_W-1:0] cur_prio;
    bit                cur_running;
    bit                cur_known;
    t_result           pending[$];
    int                failures;

    function new();
        cur_id      = '0;
        cur_prio    = '0;
        cur_running = 1'b0;
        cur_known   = 1'b0;
        failures    = 0;
    endfunction

    // insert behind every entry of equal or better priority, 0 when full
    function bit enqueue_thread(input logic [ID_W-1:0] id, input logic [PRIO_W-1:0] prio);
        t_entry e;
        int     pos;
        if (ready_q.size() >= MAX_THREADS) return 1'b0;
        pos = 0;
        while (pos < ready_q.size() && ready_q[pos].prio <= prio) pos++;
        e.id   = id;
        e.prio = prio;
        ready_q.insert(pos, e);
        return 1'b1;
    endfunction

    function void reschedule(inout t_result r);
        t_entry head;
        if (cur_known && cur_running) begin
            if (!enqueue_thread(cur_id, cur_prio)) begin
                r.queue_full = 1'b1;
                return;
            end
            cur_running = 1'b0;
        end
        if (ready_q.size() == 0) begin
            r.idle = 1'b1;
            return;
        end
        head        = ready_q.pop_front();
        r.switched  = !cur_known || head.id != cur_id;
        cur_id      = head.id;
        cur_prio    = head.prio;
        cur_running = 1'b1;
        cur_known   = 1'b1;
    endfunction

    function void note_command(input t_mode mode, input logic [ID_W-1:0] id,
                               input logic [PRIO_W-1:0] prio_in);
        t_result           r;
        logic [PRIO_W-1:0] prio;
        int                pos;
        r    = '0;
        prio = (int'(prio_in) >= PRIO_LEVELS) ? PRIO_W'(PRIO_LEVELS - 1) : prio_in;
        case (mode)
            MODE_READY: begin
                if (enqueue_thread(id, prio)) begin
                    if (cur_known && cur_id == id) cur_running = 1'b0;
                end else begin
                    r.queue_full = 1'b1;
                end
            end
            MODE_RESCHED: begin
                reschedule(r);
            end
            MODE_KILL: begin
                // only the first matching entry goes
                pos = -1;
                foreach (ready_q[i]) begin
                    if (pos < 0 && ready_q[i].id == id) pos = i;
                end
                if (pos >= 0) ready_q.delete(pos);
                if (cur_known && cur_id == id) cur_running = 1'b0;
                reschedule(r);
            end
            default: begin
                cur_running = 1'b0;
                reschedule(r);
            end
        endcase
        r.running_id    = cur_id;
        r.running_valid = cur_running;
        r.ready_count   = CNT_W'(ready_q.size());
        pending.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    function void check_result(input logic [M_TDATA_W-1:0] tdata);
        t_result got;
        t_result want;
        got = t_result'(tdata[$bits(t_result)-1:0]);
        if (pending.size() == 0) begin
            $error("result transfer with no command outstanding: %h", tdata);
            failures++;
            return;
        end
        want = pending.pop_front();
        compare_field("running_id", 8'(want.running_id), 8'(got.running_id));
        compare_field("running_valid", 8'(want.running_valid), 8'(got.running_valid));
        compare_field("idle", 8'(want.idle), 8'(got.idle));
        compare_field("switched", 8'(want.switched), 8'(got.switched));
        compare_field("queue_full", 8'(want.queue_full), 8'(got.queue_full));
        compare_field("ready_count", 8'(want.ready_count), 8'(got.ready_count));
    endfunction
endclass

module priority_ready_queue_scheduler_tb;

    // traffic profiles of the random phases
    localparam int PROF_FILL  = 0;
    localparam int PROF_MIX   = 1;
    localparam int PROF_DRAIN = 2;

    localparam int CMD_TARGET = 1350;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    // mode[1:0] thread_id[6:2] priority_req[12:7] zero[15:13]
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // running_id[4:0] running_valid[5] idle[6] switched[7] queue_full[8]
    // ready_count[14:9] zero[15]
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    bit src_gaps_on  = 1'b1;
    bit sink_gaps_on = 1'b1;
    int sink_hold    = 0;
    int cmds_sent    = 0;

    sched_checker chk = new();

    always #10 i_clk = ~i_clk;

    priority_ready_queue_scheduler i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_mode pick_mode(input int profile);
        int r;
        int w_ready;
        int w_resched;
        int w_kill;
        r = $urandom_range(0, 99);
        case (profile)
            PROF_FILL: begin
                w_ready = 75; w_resched = 15; w_kill = 5;
            end
            PROF_MIX: begin
                w_ready = 45; w_resched = 25; w_kill = 15;
            end
            default: begin
                w_ready = 15; w_resched = 35; w_kill = 30;
            end
        endcase
        if (r < w_ready) return MODE_READY;
        if (r < w_ready + w_resched) return MODE_RESCHED;
        if (r < w_ready + w_resched + w_kill) return MODE_KILL;
        return MODE_SUSPEND;
    endfunction

    // favor threads already known so kills hit and duplicates show up
    function automatic logic [ID_W-1:0] pick_thread();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && chk.ready_q.size() > 0) begin
            return chk.ready_q[$urandom_range(0, chk.ready_q.size() - 1)].id;
        end
        if (r < 60 && chk.cur_known) return chk.cur_id;
        return ID_W'($urandom_range(0, MAX_THREADS - 1));
    endfunction

    // a narrow band makes ties common, the rest spans the whole field
    function automatic logic [PRIO_W-1:0] pick_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return PRIO_W'($urandom_range(0, 3));
        if (r < 45) return $urandom_range(0, 1) ? '1 : '0;
        return PRIO_W'($urandom_range(0, (1 << PRIO_W) - 1));
    endfunction

    // one command transfer; tvalid stays up when the next one follows at once
    task automatic send_cmd(input t_mode mode, input logic [ID_W-1:0] id,
                            input logic [PRIO_W-1:0] prio);
        int gap;
        gap = pick_gap(src_gaps_on);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tdata  <= S_TDATA_W'({prio, id, mode});
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        chk.note_command(mode, id, prio);
        cmds_sent++;
    endtask

    task automatic send_random(input int profile);
        t_mode mode;
        mode = pick_mode(profile);
        send_cmd(mode, pick_thread(), pick_prio());
    endtask

    // hold off the sender until every outstanding result has been taken
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (chk.pending.size() != 0) @(posedge i_clk);
    endtask

    // result side back pressure
    always @(posedge i_clk) begin : sink_pace
        int g;
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end else begin
            g = pick_gap(sink_gaps_on);
            if (g > 0) begin
                m_tready  <= 1'b0;
                sink_hold <= g - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // every result transfer is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) chk.check_result(m_tdata);
    end

    initial begin : stimulus
        int profile;
        int phase_len;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue: reschedule, suspend and kill all come back idle
        send_cmd(MODE_RESCHED, 5'd0, 6'd0);
        send_cmd(MODE_SUSPEND, 5'd0, 6'd0);
        send_cmd(MODE_KILL, 5'd31, 6'd63);
        // extremes of id and priority, a tie, and one thread queued twice
        send_cmd(MODE_READY, 5'd0, 6'd63);
        send_cmd(MODE_READY, 5'd31, 6'd0);
        send_cmd(MODE_READY, 5'd5, 6'd0);
        send_cmd(MODE_READY, 5'd5, 6'd32);
        // first pick ever
        send_cmd(MODE_RESCHED, 5'd0, 6'd0);
        // make-ready of the running thread drops its running mark
        send_cmd(MODE_READY, 5'd31, 6'd0);
        send_cmd(MODE_RESCHED, 5'd0, 6'd0);
        // kill of the current thread while it is also queued once more
        send_cmd(MODE_KILL, 5'd5, 6'd0);
        // re-queue of the running thread picks it straight back
        send_cmd(MODE_RESCHED, 5'd0, 6'd0);
        send_cmd(MODE_SUSPEND, 5'd0, 6'd0);
        // kill of a thread neither queued nor current
        send_cmd(MODE_KILL, 5'd17, 6'd0);
        // kill of the current thread with an empty queue
        send_cmd(MODE_KILL, 5'd0, 6'd0);
        send_cmd(MODE_RESCHED, 5'd0, 6'd0);

        // fill to the brim: insert into a full queue, then re-queue into it
        send_cmd(MODE_READY, 5'd3, 6'd10);
        send_cmd(MODE_RESCHED, 5'd0, 6'd0);
        repeat (MAX_THREADS + 1) begin
            send_cmd(MODE_READY, ID_W'($urandom_range(0, MAX_THREADS - 1)), pick_prio());
        end
        send_cmd(MODE_RESCHED, 5'd0, 6'd0);
        send_cmd(MODE_KILL, 5'd3, 6'd0);
        send_cmd(MODE_SUSPEND, 5'd0, 6'd0);
        send_cmd(MODE_READY, 5'd3, 6'd63);
        wait_results_done();

        // random phases, each with its own mix and pacing
        while (cmds_sent < CMD_TARGET) begin
            profile      = $urandom_range(PROF_FILL, PROF_DRAIN);
            phase_len    = $urandom_range(40, 150);
            src_gaps_on  = ($urandom_range(0, 3) != 0);
            sink_gaps_on <= ($urandom_range(0, 3) != 0);
            repeat (phase_len) send_random(profile);
            if ($urandom_range(0, 1) != 0) wait_results_done();
        end

        wait_results_done();
        repeat (100) @(posedge i_clk);
        if (chk.failures == 0 && chk.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hard limit, well past the slowest legal run
    initial begin : watchdog
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
